// ===== rtl/core/elfnote_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package elfnote_pkg;

  // Fixed header size of one note record, in bytes
  localparam int unsigned HDR_BYTES = 12;

  // Parser phase codes, which double as the byte role codes
  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_NAME     = 3'd1;
  localparam logic [2:0] PH_NAME_PAD = 3'd2;
  localparam logic [2:0] PH_DESC     = 3'd3;
  localparam logic [2:0] PH_DESC_PAD = 3'd4;

  // Sticky error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNC_HDR = 2'd1;
  localparam logic [1:0] ERR_TRUNC_PAY = 2'd2;

  localparam logic [31:0] BUILD_ID_TYPE = 32'd3;
  localparam logic [31:0] GNU_NAME_LEN  = 32'd4;

  typedef struct packed {
    logic [2:0]  role;
    logic [31:0] ntype;
    logic        done;
    logic        bid;
    logic [1:0]  err;
  } result_t;

  // Expected bytes of the "GNU\0" owner name
  function automatic logic [7:0] gnu_byte(input logic [1:0] pos);
    logic [7:0] val;
    case (pos)
      2'd0:    val = 8'h47;
      2'd1:    val = 8'h4E;
      2'd2:    val = 8'h55;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Zero padding up to the next multiple of 4
  function automatic logic [1:0] pad_of(input logic [31:0] len);
    return 2'(3'd4 - {1'b0, len[1:0]});
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/elf_note_record_deframer_top.sv =====
// An accepted input byte's result is on the output register in the cycle after it is accepted.
// Throughput: one byte per cycle; a new byte is taken only while
// the output register is empty or being drained in the same cycle.
// Reset (rst, synchronous) returns the parser to the start of a header,
// clears lengths, type, build-id tracking, the sticky error and big_endian.
`timescale 1ns / 1ps
`default_nettype none

module elf_note_record_deframer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        section_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       byte_role,
  output logic [31:0]      note_type,
  output logic             record_done,
  output logic             build_id_byte,
  output logic [1:0]       error_code
);

  import elfnote_pkg::*;

  logic        big_endian;
  logic [2:0]  phase, phase_next;
  logic [31:0] remaining, remaining_next;
  logic [3:0]  hdr_idx, hdr_idx_next;
  logic [31:0] word_gather, word_gather_next;
  logic [31:0] name_length, name_length_next;
  logic [31:0] desc_length, desc_length_next;
  logic [31:0] record_type, record_type_next;
  logic [2:0]  name_pos, name_pos_next;
  logic        name_matches, name_matches_next;
  logic        build_id_taken, build_id_taken_next;
  logic        build_id_live, build_id_live_next;
  logic [1:0]  error_latch, error_latch_next;
  result_t     res, res_next;

  logic        accept;
  logic        go_name, go_desc, finish, last_rem;
  logic [31:0] gather_base;
  logic [1:0]  pad;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign last_rem  = (remaining == 32'd1);

  always_comb begin
    phase_next          = phase;
    remaining_next      = remaining;
    hdr_idx_next        = hdr_idx;
    word_gather_next    = word_gather;
    name_length_next    = name_length;
    desc_length_next    = desc_length;
    record_type_next    = record_type;
    name_pos_next       = name_pos;
    name_matches_next   = name_matches;
    build_id_taken_next = build_id_taken;
    build_id_live_next  = build_id_live;
    error_latch_next    = error_latch;
    go_name             = 1'b0;
    go_desc             = 1'b0;
    finish              = 1'b0;
    gather_base         = '0;
    pad                 = '0;
    res_next.role       = phase;
    res_next.ntype      = record_type;
    res_next.done       = 1'b0;
    res_next.bid        = 1'b0;
    res_next.err        = ERR_NONE;

    case (phase)
      PH_NAME: begin
        if (name_pos[2] || data_byte != gnu_byte(name_pos[1:0])) begin
          name_matches_next = 1'b0;
        end
        if (!name_pos[2]) begin
          name_pos_next = name_pos + 3'd1;
        end
        remaining_next = remaining - 32'd1;
        if (last_rem) begin
          pad = pad_of(name_length);
          if (pad != 2'd0) begin
            phase_next     = PH_NAME_PAD;
            remaining_next = {30'd0, pad};
          end else begin
            go_desc = 1'b1;
          end
        end
      end
      PH_NAME_PAD: begin
        remaining_next = remaining - 32'd1;
        if (last_rem) begin
          go_desc = 1'b1;
        end
      end
      PH_DESC: begin
        res_next.bid   = build_id_live;
        remaining_next = remaining - 32'd1;
        if (last_rem) begin
          pad = pad_of(desc_length);
          if (pad != 2'd0) begin
            phase_next     = PH_DESC_PAD;
            remaining_next = {30'd0, pad};
          end else begin
            finish = 1'b1;
          end
        end
      end
      PH_DESC_PAD: begin
        remaining_next = remaining - 32'd1;
        if (last_rem) begin
          finish = 1'b1;
        end
      end
      default: begin
        res_next.role  = PH_HEADER;
        res_next.ntype = '0;
        gather_base    = (hdr_idx[1:0] == 2'd0) ? 32'd0 : word_gather;
        if (big_endian) begin
          word_gather_next = {gather_base[23:0], data_byte};
        end else begin
          case (hdr_idx[1:0])
            2'd0:    word_gather_next = gather_base | {24'd0, data_byte};
            2'd1:    word_gather_next = gather_base | {16'd0, data_byte, 8'd0};
            2'd2:    word_gather_next = gather_base | {8'd0, data_byte, 16'd0};
            default: word_gather_next = gather_base | {data_byte, 24'd0};
          endcase
        end
        if (hdr_idx[1:0] == 2'd3) begin
          case (hdr_idx[3:2])
            2'd0:    name_length_next = word_gather_next;
            2'd1:    desc_length_next = word_gather_next;
            default: record_type_next = word_gather_next;
          endcase
        end
        if (hdr_idx == 4'(HDR_BYTES - 1)) begin
          name_matches_next = (name_length == GNU_NAME_LEN);
          res_next.ntype    = record_type_next;
          go_name           = 1'b1;
        end else begin
          hdr_idx_next = hdr_idx + 4'd1;
        end
      end
    endcase

    if (go_name) begin
      if (name_length_next != 32'd0) begin
        phase_next     = PH_NAME;
        remaining_next = name_length_next;
        name_pos_next  = '0;
      end else begin
        go_desc = 1'b1;
      end
    end

    if (go_desc) begin
      if (desc_length_next != 32'd0) begin
        phase_next         = PH_DESC;
        remaining_next     = desc_length_next;
        build_id_live_next = (record_type_next == BUILD_ID_TYPE) && name_matches_next
                             && !build_id_taken;
        if (build_id_live_next) begin
          build_id_taken_next = 1'b1;
        end
      end else begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      phase_next         = PH_HEADER;
      hdr_idx_next       = '0;
      remaining_next     = '0;
      build_id_live_next = 1'b0;
    end

    // Section end: restart at a header; if cut short, latch the first error
    if (section_last) begin
      if (!finish && error_latch == ERR_NONE) begin
        error_latch_next = (phase_next == PH_HEADER) ? ERR_TRUNC_HDR : ERR_TRUNC_PAY;
      end
      phase_next         = PH_HEADER;
      hdr_idx_next       = '0;
      remaining_next     = '0;
      build_id_live_next = 1'b0;
    end

    res_next.done = finish;
    res_next.err  = error_latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian     <= 1'b0;
      phase          <= PH_HEADER;
      remaining      <= '0;
      hdr_idx        <= '0;
      word_gather    <= '0;
      name_length    <= '0;
      desc_length    <= '0;
      record_type    <= '0;
      name_pos       <= '0;
      name_matches   <= 1'b1;
      build_id_taken <= 1'b0;
      build_id_live  <= 1'b0;
      error_latch    <= ERR_NONE;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        big_endian <= cfg_data;
      end
      if (accept) begin
        phase          <= phase_next;
        remaining      <= remaining_next;
        hdr_idx        <= hdr_idx_next;
        word_gather    <= word_gather_next;
        name_length    <= name_length_next;
        desc_length    <= desc_length_next;
        record_type    <= record_type_next;
        name_pos       <= name_pos_next;
        name_matches   <= name_matches_next;
        build_id_taken <= build_id_taken_next;
        build_id_live  <= build_id_live_next;
        error_latch    <= error_latch_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register holds until drained
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign byte_role     = res.role;
  assign note_type     = res.ntype;
  assign record_done   = res.done;
  assign build_id_byte = res.bid;
  assign error_code    = res.err;

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (error_latch != ERR_NONE) |=> (error_latch == $past(error_latch)))
    else $error("sticky error changed");

  a_bid_desc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && build_id_byte) |-> (byte_role == PH_DESC && note_type == BUILD_ID_TYPE))
    else $error("build-id flag outside a type 3 descriptor");

  a_live_taken: assert property (@(posedge clk) disable iff (rst)
    build_id_live |-> (build_id_taken && (phase == PH_DESC || phase == PH_DESC_PAD)))
    else $error("build-id live without being taken");

  a_hdr_idx: assert property (@(posedge clk) disable iff (rst)
    hdr_idx < 4'(HDR_BYTES))
    else $error("header index out of range");

endmodule

`default_nettype wire
